>>> hw/rtl/ffsa_pkg.sv
// package for the first-fit span allocator
// holds request, status and sequencer state codes; no dependencies
package ffsa_pkg;
    typedef enum logic [0:0] {
        REQ_INSERT = 1'b0,
        REQ_ALLOC  = 1'b1
    } req_type_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_NOFIT = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_DECIDE,
        S_POP_LAST,
        S_POP_RD,
        S_POP_CMP,
        S_PUSH_START,
        S_PUSH_RD,
        S_PUSH_CMP,
        S_DONE
    } fsm_state_t;
endpackage

>>> hw/rtl/ffsa_if.sv
// valid/ready channel interface carrying one payload word
// depends on nothing; payload width set by parameter
interface ffsa_if #(
    parameter int W = 8
) (
    input logic clk
);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> hw/rtl/first_fit_span_allocator_top.sv
// first-fit span allocator: one address-ordered min-heap per size class
// insert: a push that sifts the new address up its class heap
// allocate: a scan of the class heads from the request's class upward, a pop sift
// and a push of the tail
// one transaction in flight; a finished result
// waits in its own output register so a stalled receiver only holds the done state
// reset: class counts and the sequencer clear asynchronously; heap memory is not cleared
// depends on ffsa_pkg, ffsa_if, ffsa_heap_mem
module first_fit_span_allocator_top
    import ffsa_pkg::*;
#(
    parameter int NUM_CLASSES = 9,
    parameter int HEAP_DEPTH = 1024,
    parameter int ADDR_BITS = 20
) (
    input logic clk,
    input logic rst_n,
    ffsa_if.sink   in_ch,
    ffsa_if.source out_ch
);
    localparam int CB = $clog2(NUM_CLASSES);
    localparam int HB = $clog2(HEAP_DEPTH);
    localparam int MB = CB + HB;
    localparam int NB = HB + 1;
    localparam int MD = NUM_CLASSES * HEAP_DEPTH;

    // input fields
    logic                 in_kind;
    logic [3:0]           in_len;
    logic [ADDR_BITS-1:0] in_addr;
    assign in_kind = in_ch.data[ADDR_BITS+4];
    assign in_len  = in_ch.data[ADDR_BITS+3:ADDR_BITS];
    assign in_addr = in_ch.data[ADDR_BITS-1:0];

    fsm_state_t state_reg, state_next;
    logic [NB-1:0] count_reg [NUM_CLASSES];
    logic          kind_reg;
    logic [3:0]    len_reg;
    logic [ADDR_BITS-1:0] ceil_reg;
    logic [CB-1:0] cls_reg, cls_next;
    logic          found_reg, found_next;
    logic [CB-1:0] best_c_reg, best_c_next;
    logic [ADDR_BITS-1:0] best_a_reg, best_a_next;
    logic [ADDR_BITS-1:0] key_reg, key_next;
    logic [HB-1:0] idx_reg, idx_next;
    logic [NB-1:0] n_reg, n_next;
    logic [ADDR_BITS-1:0] lch_reg, lch_next;
    logic          rd_half_reg, rd_half_next;
    logic          out_valid_reg, out_valid_next;
    logic          granted_reg, granted_next;
    logic [ADDR_BITS-1:0] gaddr_reg, gaddr_next;
    status_t       status_reg, status_next;
    logic          cnt_we;
    logic [CB-1:0] cnt_cls;
    logic [NB-1:0] cnt_val;
    logic          out_load;
    logic          out_kind_reg;
    logic          out_granted_reg;
    logic [ADDR_BITS-1:0] out_gaddr_reg;
    status_t       out_status_reg;

    // memory port signals
    logic                 we;
    logic [MB-1:0]        waddr, raddr;
    logic [ADDR_BITS-1:0] wdata, rdata;

    ffsa_heap_mem #(.AW(MB), .DW(ADDR_BITS), .DEPTH(MD)) u_mem (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    function automatic logic [MB-1:0] maddr(input logic [CB-1:0] c, input logic [HB-1:0] i);
        logic [MB+3:0] t;
        t = (MB+4)'(c) * (MB+4)'(HEAP_DEPTH) + (MB+4)'(i);
        return t[MB-1:0];
    endfunction

    logic [NB:0] lc, rc;
    logic [CB:0] lenm1;
    logic [CB:0] restc;
    logic [ADDR_BITS-1:0] tail_a;
    logic [HB-1:0] parent;
    always_comb
    begin
        lc     = (NB+1)'({idx_reg, 1'b1});
        rc     = lc + (NB+1)'(1);
        lenm1  = (CB+1)'(len_reg) - (CB+1)'(1);
        restc  = (CB+1)'(best_c_reg) - lenm1;
        tail_a = best_a_reg + ADDR_BITS'(len_reg);
        parent = HB'((idx_reg - HB'(1)) >> 1);
    end

    // sequencer: next state, memory accesses, result
    always_comb
    begin
        state_next = state_reg;
        cls_next = cls_reg; found_next = found_reg; best_c_next = best_c_reg;
        best_a_next = best_a_reg; key_next = key_reg; idx_next = idx_reg;
        n_next = n_reg; lch_next = lch_reg; rd_half_next = rd_half_reg;
        out_valid_next = out_valid_reg; granted_next = granted_reg;
        gaddr_next = gaddr_reg; status_next = status_reg;
        we = 1'b0; waddr = '0; wdata = '0; raddr = '0;
        cnt_we = 1'b0; cnt_cls = cls_reg; cnt_val = '0;
        out_load = 1'b0;
        in_ch.ready = 1'b0;
        if (out_ch.valid && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                in_ch.ready = 1'b1;
                if (in_ch.valid && in_ch.ready)
                begin
                    granted_next = 1'b0; gaddr_next = '0; status_next = ST_OK;
                    found_next = 1'b0;
                    cls_next = CB'(in_len - 4'd1);
                    key_next = in_addr;
                    if (in_kind == REQ_INSERT)
                    begin
                        if (in_len == 4'd0)
                            state_next = S_DONE;
                        else if (32'(in_len) > NUM_CLASSES)
                        begin
                            status_next = ST_FULL; state_next = S_DONE;
                        end
                        else
                            state_next = S_PUSH_START;
                    end
                    else if (in_len == 4'd0 || 32'(in_len) > NUM_CLASSES)
                    begin
                        status_next = ST_NOFIT; state_next = S_DONE;
                    end
                    else
                        state_next = S_SCAN_RD;
                end
            end
            S_SCAN_RD:
            begin
                raddr = maddr(cls_reg, '0);
                state_next = S_SCAN_CMP;
            end
            S_SCAN_CMP:
            begin
                if (count_reg[cls_reg] != '0 && (!found_reg || rdata < best_a_reg))
                begin
                    found_next = 1'b1; best_a_next = rdata; best_c_next = cls_reg;
                end
                if (32'(cls_reg) == NUM_CLASSES - 1)
                    state_next = S_DECIDE;
                else
                begin
                    cls_next = cls_reg + CB'(1);
                    state_next = S_SCAN_RD;
                end
            end
            S_DECIDE:
            begin
                if (!found_reg || best_a_reg > ceil_reg)
                begin
                    status_next = ST_NOFIT; state_next = S_DONE;
                end
                else
                begin
                    granted_next = 1'b1; gaddr_next = best_a_reg;
                    cls_next = best_c_reg;
                    n_next = count_reg[best_c_reg] - NB'(1);
                    cnt_we = 1'b1; cnt_cls = best_c_reg;
                    cnt_val = count_reg[best_c_reg] - NB'(1);
                    raddr = maddr(best_c_reg, HB'(count_reg[best_c_reg] - NB'(1)));
                    idx_next = '0;
                    state_next = S_POP_LAST;
                end
            end
            S_POP_LAST:
            begin
                key_next = rdata;
                state_next = S_POP_RD;
            end
            S_POP_RD:
            begin
                // fetch left child, then right child
                if (lc >= (NB+1)'(n_reg))
                begin
                    if (n_reg != '0)
                    begin
                        we = 1'b1; waddr = maddr(cls_reg, idx_reg); wdata = key_reg;
                    end
                    state_next = S_PUSH_START;
                end
                else
                begin
                    raddr = maddr(cls_reg, HB'(lc));
                    rd_half_next = 1'b0;
                    state_next = S_POP_CMP;
                end
            end
            S_POP_CMP:
            begin
                if (!rd_half_reg)
                begin
                    lch_next = rdata;
                    if (rc < (NB+1)'(n_reg))
                    begin
                        raddr = maddr(cls_reg, HB'(rc));
                        rd_half_next = 1'b1;
                    end
                    else if (key_reg <= rdata)
                    begin
                        we = 1'b1; waddr = maddr(cls_reg, idx_reg); wdata = key_reg;
                        state_next = S_PUSH_START;
                    end
                    else
                    begin
                        we = 1'b1; waddr = maddr(cls_reg, idx_reg); wdata = rdata;
                        idx_next = HB'(lc);
                        state_next = S_POP_RD;
                    end
                end
                else
                begin
                    if (rdata < lch_reg)
                    begin
                        if (key_reg <= rdata)
                        begin
                            we = 1'b1; waddr = maddr(cls_reg, idx_reg); wdata = key_reg;
                            state_next = S_PUSH_START;
                        end
                        else
                        begin
                            we = 1'b1; waddr = maddr(cls_reg, idx_reg); wdata = rdata;
                            idx_next = HB'(rc);
                            state_next = S_POP_RD;
                        end
                    end
                    else if (key_reg <= lch_reg)
                    begin
                        we = 1'b1; waddr = maddr(cls_reg, idx_reg); wdata = key_reg;
                        state_next = S_PUSH_START;
                    end
                    else
                    begin
                        we = 1'b1; waddr = maddr(cls_reg, idx_reg); wdata = lch_reg;
                        idx_next = HB'(lc);
                        state_next = S_POP_RD;
                    end
                end
            end
            S_PUSH_START:
            begin
                // after a pop, push the tail if any; otherwise push the request
                if (granted_reg && restc == '0)
                    state_next = S_DONE;
                else
                begin
                    if (granted_reg)
                    begin
                        cls_next = CB'(restc - (CB+1)'(1));
                        key_next = tail_a;
                        cnt_cls = CB'(restc - (CB+1)'(1));
                    end
                    if (32'(count_reg[cnt_cls]) >= HEAP_DEPTH)
                    begin
                        status_next = ST_FULL; state_next = S_DONE;
                    end
                    else
                    begin
                        cnt_we = 1'b1; cnt_val = count_reg[cnt_cls] + NB'(1);
                        idx_next = HB'(count_reg[cnt_cls]);
                        state_next = S_PUSH_RD;
                    end
                end
            end
            S_PUSH_RD:
            begin
                if (idx_reg == '0)
                begin
                    we = 1'b1; waddr = maddr(cls_reg, idx_reg); wdata = key_reg;
                    state_next = S_DONE;
                end
                else
                begin
                    raddr = maddr(cls_reg, parent);
                    state_next = S_PUSH_CMP;
                end
            end
            S_PUSH_CMP:
            begin
                if (rdata <= key_reg)
                begin
                    we = 1'b1; waddr = maddr(cls_reg, idx_reg); wdata = key_reg;
                    state_next = S_DONE;
                end
                else
                begin
                    we = 1'b1; waddr = maddr(cls_reg, idx_reg); wdata = rdata;
                    idx_next = parent;
                    state_next = S_PUSH_RD;
                end
            end
            S_DONE:
            begin
                // hand the result over once the output register is free
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_load = 1'b1;
                    out_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_CLASSES; i++)
            begin
                count_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
            if (cnt_we)
            begin
                count_reg[cnt_cls] <= cnt_val;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            kind_reg <= in_kind; len_reg <= in_len; ceil_reg <= in_addr;
        end
        cls_reg <= cls_next; found_reg <= found_next; best_c_reg <= best_c_next;
        best_a_reg <= best_a_next; key_reg <= key_next; idx_reg <= idx_next;
        n_reg <= n_next; lch_reg <= lch_next; rd_half_reg <= rd_half_next;
        granted_reg <= granted_next; gaddr_reg <= gaddr_next; status_reg <= status_next;
        if (out_load)
        begin
            out_kind_reg <= kind_reg; out_granted_reg <= granted_reg;
            out_gaddr_reg <= gaddr_reg; out_status_reg <= status_reg;
        end
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = {out_granted_reg, out_gaddr_reg, out_status_reg};

    // checks
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !in_ch.ready)
        else $error("input accepted while busy");
    a_grant_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_granted_reg) |-> (out_gaddr_reg == '0))
        else $error("address without grant");
    a_insert_no_grant: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_kind_reg == REQ_INSERT) |-> !out_granted_reg)
        else $error("insert produced grant");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.ready) |=> (out_ch.valid && $stable(out_ch.data)))
        else $error("result dropped");
endmodule

>>> hw/rtl/ffsa_heap_mem.sv
// heap storage memory: one write port, one registered read port
// depends on nothing
module ffsa_heap_mem #(
    parameter int AW = 10,
    parameter int DW = 20,
    parameter int DEPTH = 1024
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);
    logic [DW-1:0] mem [DEPTH];

    // synchronous write and read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> tb/testbench.sv
// testbench for first_fit_span_allocator_top: directed and random span traffic
// checked against an in-bench model of the per-class free lists
// depends on ffsa_pkg, ffsa_if and the allocator rtl
module testbench;
    import ffsa_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLASSES = 9;
    localparam int DEPTH = 1024;
    localparam int ABITS = 20;
    localparam int TAIL_CYCLES = 200;
    localparam longint CYCLE_LIMIT = 4000000;

    typedef logic [ABITS-1:0] addr_t;

    typedef struct packed {
        req_type_t  kind;
        logic [3:0] len;
        addr_t      addr;
    } span_req_t;

    typedef struct packed {
        logic    granted;
        addr_t   addr;
        status_t status;
    } span_res_t;

    logic clk;
    logic rst_n;

    ffsa_if #(.W($bits(span_req_t))) in_ch (.clk(clk));
    ffsa_if #(.W($bits(span_res_t))) out_ch (.clk(clk));

    first_fit_span_allocator_top #(
        .NUM_CLASSES(CLASSES),
        .HEAP_DEPTH(DEPTH),
        .ADDR_BITS(ABITS)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(in_ch),
        .out_ch(out_ch)
    );

    // free start addresses per class, kept sorted lowest first
    addr_t free_spans[CLASSES][$];
    span_res_t pending_grants[$];
    int errors;
    longint cycles;
    int stall_mode;

    // clock
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // cycle limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // add a span address to a class, false when the class is full
    function automatic bit free_list_add(int c, addr_t a);
        int pos;
        if (free_spans[c].size() >= DEPTH)
            return 0;
        pos = 0;
        while (pos < free_spans[c].size() && free_spans[c][pos] <= a)
            pos++;
        free_spans[c].insert(pos, a);
        return 1;
    endfunction

    // work out the outcome of one request and update the free lists
    function automatic span_res_t allocate_span(span_req_t r);
        span_res_t res;
        int best_c;
        addr_t best_a;
        int rest;
        res = '{granted: 1'b0, addr: '0, status: ST_OK};
        if (r.kind == REQ_INSERT)
        begin
            if (r.len == 0)
                res.status = ST_OK;
            else if (r.len > CLASSES)
                res.status = ST_FULL;
            else if (!free_list_add(r.len - 1, r.addr))
                res.status = ST_FULL;
        end
        else if (r.len == 0 || r.len > CLASSES)
            res.status = ST_NOFIT;
        else
        begin
            best_c = -1;
            best_a = '0;
            for (int c = r.len - 1; c < CLASSES; c++)
            begin
                if (free_spans[c].size() != 0 && (best_c < 0 || free_spans[c][0] < best_a))
                begin
                    best_c = c;
                    best_a = free_spans[c][0];
                end
            end
            if (best_c < 0 || best_a > r.addr)
                res.status = ST_NOFIT;
            else
            begin
                res.granted = 1'b1;
                res.addr = best_a;
                void'(free_spans[best_c].pop_front());
                rest = best_c + 1 - r.len;
                if (rest != 0 && !free_list_add(rest - 1, addr_t'(best_a + r.len)))
                    res.status = ST_FULL;
            end
        end
        return res;
    endfunction

    // send one request and record its expected outcome on acceptance
    task automatic send_req(req_type_t kind, int len, addr_t addr);
        span_req_t r;
        r.kind = kind;
        r.len = 4'(len);
        r.addr = addr;
        in_ch.valid <= 1'b1;
        in_ch.data <= r;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        pending_grants.push_back(allocate_span(r));
    endtask

    // drop valid for a number of cycles
    task automatic sender_gap(int n);
        in_ch.valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic wait_drained();
        sender_gap(0);
        while (pending_grants.size() != 0)
            @(posedge clk);
    endtask

    // receiver stall pattern, switching between modes
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
        begin
            if ($urandom_range(0, 199) == 0)
                stall_mode <= $urandom_range(0, 3);
            case (stall_mode)
                0: out_ch.ready <= 1'b1;
                1: out_ch.ready <= ($urandom_range(0, 3) != 0);
                2: out_ch.ready <= ($urandom_range(0, 1) != 0);
                default: out_ch.ready <= ($urandom_range(0, 9) == 0);
            endcase
        end
    end

    // result checker
    always @(posedge clk)
    begin
        span_res_t got;
        span_res_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got = out_ch.data;
            if (pending_grants.size() == 0)
            begin
                $error("unexpected transaction: %p", got);
                errors++;
            end
            else
            begin
                want = pending_grants.pop_front();
                if (got.granted !== want.granted)
                begin
                    $error("granted: expected %0d, got %0d", want.granted, got.granted);
                    errors++;
                end
                if (got.addr !== want.addr)
                begin
                    $error("grant_address: expected %0h, got %0h", want.addr, got.addr);
                    errors++;
                end
                if (got.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, got.status);
                    errors++;
                end
            end
        end
    end

    // empty lists, bad lengths, wrap of the tail address, ceiling edges
    task automatic test_basic_cases();
        send_req(REQ_ALLOC, 1, '1);
        send_req(REQ_ALLOC, 0, '1);
        send_req(REQ_ALLOC, 15, '1);
        send_req(REQ_INSERT, 0, 20'h12345);
        send_req(REQ_INSERT, 10, 20'h00100);
        send_req(REQ_INSERT, 15, 20'h00200);
        send_req(REQ_INSERT, 9, '1);
        send_req(REQ_ALLOC, 1, '1);
        send_req(REQ_ALLOC, 8, 20'h00000);
        send_req(REQ_ALLOC, 8, 20'h00001);
        send_req(REQ_INSERT, 1, 20'h00000);
        send_req(REQ_INSERT, 3, 20'h00000);
        send_req(REQ_ALLOC, 1, 20'h00000);
        send_req(REQ_ALLOC, 2, 20'h00000);
        send_req(REQ_ALLOC, 9, '1);
        sender_gap(3);
        for (int len = 1; len <= CLASSES; len++)
            send_req(REQ_INSERT, len, addr_t'(20'h80000 + len * 16));
        for (int len = CLASSES; len >= 1; len--)
            send_req(REQ_ALLOC, len, '1);
        wait_drained();
    endtask

    // random traffic in bursts, mostly valid lengths
    task automatic test_random_traffic(int count);
        int sent;
        int burst;
        int len;
        addr_t a;
        sent = 0;
        while (sent < count)
        begin
            burst = $urandom_range(1, 12);
            for (int i = 0; i < burst && sent < count; i++)
            begin
                len = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 9);
                a = addr_t'($urandom());
                if ($urandom_range(0, 1) == 0)
                    send_req(REQ_INSERT, len, a);
                else
                    send_req(REQ_ALLOC, len, ($urandom_range(0, 2) == 0) ? '1 : a);
                sent++;
            end
            if (sent == count / 2)
                wait_drained();
            else if ($urandom_range(0, 3) != 0)
                sender_gap($urandom_range(1, 60));
        end
        sender_gap(0);
    endtask

    initial
    begin
        errors = 0;
        cycles = 0;
        stall_mode = 0;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_basic_cases();
        test_random_traffic(417);
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0 && pending_grants.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

>>> sim.f
hw/rtl/ffsa_pkg.sv
hw/rtl/ffsa_if.sv
hw/rtl/ffsa_heap_mem.sv
hw/rtl/first_fit_span_allocator_top.sv
tb/testbench.sv
